// ===== sv/gnodf_pkg.sv =====
package gnodf_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_QRY,
        ST_OUT
    } t_state;

    localparam logic [15:0] FAR_VALUE   = 16'hFF00;
    localparam logic [16:0] REMOVE_STEP = 17'd512;
    localparam int          CFG_IDX_W   = 1;
    localparam logic        CFG_WIDTH   = 1'b0;
    localparam logic        CFG_HEIGHT  = 1'b1;

endpackage

// ===== sv/gnodf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, 16-bit result.
module gnodf_sqrt #(
    parameter int TW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_rad,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [15:0]   o_root,
    output logic [TW-1:0] o_tag
);
    localparam int STAGES = 16;

    logic [31:0]   r_rem  [STAGES+1];
    logic [15:0]   r_root [STAGES+1];
    logic [TW-1:0] r_tag  [STAGES+1];
    logic          r_vld  [STAGES+1];

    always_comb begin
        r_rem[0]  = i_rad;
        r_root[0] = '0;
        r_tag[0]  = i_tag;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int B = STAGES - 1 - s;
        logic [33:0] trial;
        logic [33:0] rem_ext;
        assign trial   = ({18'd0, r_root[s]} << (B + 1)) | (34'd1 << (2 * B));
        assign rem_ext = {2'b00, r_rem[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_tag[s+1] <= r_tag[s];
            if (rem_ext >= trial) begin
                r_rem[s+1]  <= r_rem[s] - trial[31:0];
                r_root[s+1] <= r_root[s] | (16'd1 << B);
            end else begin
                r_rem[s+1]  <= r_rem[s];
                r_root[s+1] <= r_root[s];
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_root  = r_root[STAGES];
    assign o_tag   = r_tag[STAGES];
endmodule

// ===== sv/gnodf_mem.sv =====
// Distance grid: one write port, one registered read port.
module gnodf_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/grid_nearest_object_distance_field.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_func i_pos_x i_pos_y i_thin
// out     | output    | o_out_valid / i_out_ready | o_distance o_in_range o_grid_updated
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
// An add in range (a thin add only when the thin phase is zero) sweeps w*h cells,
// one per cycle, through a 16-stage square root pipeline, then drains it.
// A remove reads and rewrites its cell, a query reads it. After reset a clearing
// pass writes every one of the 2^(XB+YB) grid entries (4096 with the default
// sizes), one a cycle, before the first word is taken.
// One item at a time; the result register holds while the output stalls.
module grid_nearest_object_distance_field #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64,
    parameter int CELL_SIZE  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic        i_thin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_distance,
    output logic        o_in_range,
    output logic        o_grid_updated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gnodf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    localparam int WB    = $clog2(MAX_GRID_W + 1);
    localparam int HB    = $clog2(MAX_GRID_H + 1);
    localparam int XB    = (MAX_GRID_W > 1) ? $clog2(MAX_GRID_W) : 1;
    localparam int YB    = (MAX_GRID_H > 1) ? $clog2(MAX_GRID_H) : 1;
    localparam int AW    = XB + YB;
    localparam int DEPTH = 1 << AW;
    localparam int DRAIN_LAST = 16;
    localparam int RECIP_SH   = 20;
    localparam int RECIP_M    = ((1 << RECIP_SH) + CELL_SIZE - 1) / CELL_SIZE;

    gnodf_pkg::t_state r_state, n_state;
    logic [6:0]  r_cfg_w, r_cfg_h;
    logic [1:0]  r_phase;
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [AW-1:0] r_clr;

    logic [16:0] cx, cy;
    logic        inr;
    logic [AW-1:0] in_addr;
    logic [16:0] r_cx, r_cy;
    logic [8:0]  r_a, r_b;
    logic        r_last;
    logic [4:0]  r_drain;
    logic [15:0] r_dist;
    logic        r_inr, r_upd;
    logic [AW-1:0] r_addr;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    // sqrt pipeline
    logic          sq_vld_o;
    logic [15:0]   sq_root;
    logic [AW-1:0] sq_tag;
    logic [31:0]   sq_rad;
    logic [AW-1:0] sq_tag_i;
    logic          sq_in;
    logic          r_sq_v;
    logic [15:0]   r_sq_root;
    logic [AW-1:0] r_sq_addr;

    always_comb begin
        w_eff = (r_cfg_w == 7'd0) ? WB'(1)
              : ({25'd0, r_cfg_w} > 32'(MAX_GRID_W)) ? WB'(MAX_GRID_W) : WB'(r_cfg_w);
        h_eff = (r_cfg_h == 7'd0) ? HB'(1)
              : ({25'd0, r_cfg_h} > 32'(MAX_GRID_H)) ? HB'(MAX_GRID_H) : HB'(r_cfg_h);
    end

    // truncating divide toward zero: reciprocal multiply on the magnitude,
    // exact for any magnitude below 2^16 with the default CELL_SIZE of 4, then restore the sign
    always_comb begin
        logic [15:0] mag_x, mag_y;
        logic [36:0] prod_x, prod_y;
        logic [16:0] quo_x, quo_y;
        mag_x  = i_pos_x[15] ? 16'(-i_pos_x) : i_pos_x;
        mag_y  = i_pos_y[15] ? 16'(-i_pos_y) : i_pos_y;
        prod_x = {21'd0, mag_x} * 37'(RECIP_M);
        prod_y = {21'd0, mag_y} * 37'(RECIP_M);
        quo_x  = prod_x[RECIP_SH+16:RECIP_SH];
        quo_y  = prod_y[RECIP_SH+16:RECIP_SH];
        cx     = i_pos_x[15] ? -quo_x : quo_x;
        cy     = i_pos_y[15] ? -quo_y : quo_y;
    end

    assign inr = !cx[16] && (cx < 17'(w_eff)) && !cy[16] && (cy < 17'(h_eff))
               && (i_func != gnodf_pkg::FUNC_NOP);
    assign in_addr = AW'(cx[XB-1:0]) | AW'({cy[YB-1:0], {XB{1'b0}}});

    // distance squared of the current sweep cell
    logic signed [17:0] dx, dy;
    logic [31:0] dsq;
    assign dx  = $signed({9'd0, r_a}) - $signed({1'b0, r_cx});
    assign dy  = $signed({9'd0, r_b}) - $signed({1'b0, r_cy});
    assign dsq = 32'(dx * dx) + 32'(dy * dy);
    // a squared distance of 65536 or more saturates the root
    assign sq_rad   = (dsq[31:16] != 16'd0) ? 32'hFFFF_FFFF : {dsq[15:0], 16'd0};
    assign sq_in    = (r_state == gnodf_pkg::ST_SWEEP);
    assign sq_tag_i = AW'(r_a[XB-1:0]) | AW'({r_b[YB-1:0], {XB{1'b0}}});

    gnodf_sqrt #(.TW(AW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_in),
        .i_rad   (sq_rad),
        .i_tag   (sq_tag_i),
        .o_valid (sq_vld_o),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    gnodf_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Root leaves the pipe while the cell is read; compare the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else begin
            r_sq_v <= sq_vld_o;
        end
        r_sq_root <= sq_root;
        r_sq_addr <= sq_tag;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mem_rdata;
        // read the incoming word's cell as it is taken
        mem_raddr = (r_state == gnodf_pkg::ST_IDLE) ? in_addr : r_addr;
        if (r_state == gnodf_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = gnodf_pkg::FAR_VALUE;
        end else if (r_state == gnodf_pkg::ST_SWEEP || r_state == gnodf_pkg::ST_DRAIN) begin
            mem_raddr = sq_tag;
            mem_waddr = r_sq_addr;
            mem_we    = r_sq_v && (r_sq_root < mem_rdata);
            mem_wdata = r_sq_root;
        end else if (r_state == gnodf_pkg::ST_RMW_WR) begin
            mem_we    = 1'b1;
            mem_wdata = ({1'b0, mem_rdata} + gnodf_pkg::REMOVE_STEP > 17'hFFFF)
                      ? 16'hFFFF : mem_rdata + 16'd512;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gnodf_pkg::ST_CLEAR:  if (r_clr == AW'(DEPTH - 1)) n_state = gnodf_pkg::ST_IDLE;
            gnodf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = gnodf_pkg::ST_OUT;
                    if (i_func == gnodf_pkg::FUNC_ADD && inr
                        && (!i_thin || r_phase == 2'd0)) n_state = gnodf_pkg::ST_SWEEP;
                    else if (i_func == gnodf_pkg::FUNC_REMOVE && inr)
                        n_state = gnodf_pkg::ST_RMW_RD;
                    else if (i_func == gnodf_pkg::FUNC_QUERY && inr)
                        n_state = gnodf_pkg::ST_QRY;
                end
            end
            gnodf_pkg::ST_SWEEP:  if (r_last) n_state = gnodf_pkg::ST_DRAIN;
            // hold until the last root has left the pipe and been written back
            gnodf_pkg::ST_DRAIN:  if (r_drain == 5'(DRAIN_LAST)) n_state = gnodf_pkg::ST_OUT;
            gnodf_pkg::ST_RMW_RD: n_state = gnodf_pkg::ST_RMW_WR;
            gnodf_pkg::ST_RMW_WR: n_state = gnodf_pkg::ST_OUT;
            gnodf_pkg::ST_QRY:    n_state = gnodf_pkg::ST_OUT;
            gnodf_pkg::ST_OUT:    if (i_out_ready) n_state = gnodf_pkg::ST_IDLE;
            default:              n_state = gnodf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnodf_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_phase <= 2'd0;
            r_cfg_w <= 7'd64;
            r_cfg_h <= 7'd64;
        end else begin
            r_state <= n_state;
            if (r_state == gnodf_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) begin
                if (i_cfg_index == gnodf_pkg::CFG_WIDTH) r_cfg_w <= i_cfg_data;
                else                                     r_cfg_h <= i_cfg_data;
            end
            if (r_state == gnodf_pkg::ST_IDLE && i_in_valid
                && i_func == gnodf_pkg::FUNC_ADD && i_thin) begin
                r_phase <= (r_phase >= 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
        end
    end

    // payload and sweep counters
    always_ff @(posedge i_clk) begin
        if (r_state == gnodf_pkg::ST_IDLE && i_in_valid) begin
            r_cx   <= cx;
            r_cy   <= cy;
            r_a    <= '0;
            r_b    <= '0;
            r_last <= (w_eff == WB'(1)) && (h_eff == HB'(1));
            r_addr <= in_addr;
            r_inr  <= inr;
            r_dist <= (i_func == gnodf_pkg::FUNC_QUERY) ? gnodf_pkg::FAR_VALUE : 16'd0;
            r_upd  <= inr && ((i_func == gnodf_pkg::FUNC_REMOVE)
                      || (i_func == gnodf_pkg::FUNC_ADD && (!i_thin || r_phase == 2'd0)));
        end else if (r_state == gnodf_pkg::ST_SWEEP) begin
            r_drain <= '0;
            // advance column, then row
            if (r_a + 9'd1 == 9'(w_eff)) begin
                r_a <= '0;
                r_b <= r_b + 9'd1;
                r_last <= (r_b + 9'd2 == 9'(h_eff)) && (w_eff == WB'(1));
            end else begin
                r_a <= r_a + 9'd1;
                r_last <= (r_a + 9'd2 == 9'(w_eff)) && (r_b + 9'd1 == 9'(h_eff));
            end
        end else if (r_state == gnodf_pkg::ST_DRAIN) begin
            r_drain <= r_drain + 5'd1;
        end else if (r_state == gnodf_pkg::ST_QRY) begin
            r_dist <= mem_rdata;
        end
    end

    assign o_in_ready     = (r_state == gnodf_pkg::ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = (r_state == gnodf_pkg::ST_OUT);
    assign o_distance     = r_dist;
    assign o_in_range     = r_inr;
    assign o_grid_updated = r_upd;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output both open");
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3) else $error("thin phase out of range");
    a_upd_inr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_grid_updated |-> o_in_range) else $error("update outside grid");
endmodule
